@@ sv/grid_bilinear_interpolator_assert.svh @@
// Assertion macros used by the checker file gbi_checker.sv.
`ifndef GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH
`define GRID_BILINEAR_INTERPOLATOR_ASSERT_SVH

// Clocked check, quiet while reset is asserted.
`define GBI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds during reset.
`define GBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ sv/gbi_pkg.sv @@
`timescale 1ns / 1ps

package gbi_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_LOW   = 3'd0,
        CFG_X_HIGH  = 3'd1,
        CFG_Y_LOW   = 3'd2,
        CFG_Y_HIGH  = 3'd3,
        CFG_X_SCALE = 3'd4,
        CFG_Y_SCALE = 3'd5,
        CFG_X_USED  = 3'd6,
        CFG_Y_USED  = 3'd7
    } cfg_idx_t;

    // Item kinds
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    // Per-axis settings handed to a locate unit
    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic        [31:0] scale;
        logic        [6:0]  used;
    } axis_cfg_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int USED_W     = 7;

    // Q16.16 one, used as a saturated fraction
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;
    // Half an LSB of the Q16.16 result in the Q16.48 sum
    localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_8000_0000;

    // Register reset values
    localparam logic signed [31:0] LOW_RST   = 32'sh0000_0000;
    localparam logic signed [31:0] HIGH_RST  = 32'sh0001_0000;
    localparam logic        [31:0] SCALE_RST = 32'h003F_0000;
    localparam logic        [6:0]  USED_RST  = 7'd64;

endpackage

@@ sv/gbi_item_if.sv @@
`timescale 1ns / 1ps

// Input channel: grid sample writes and point queries
interface gbi_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic        [5:0]  x_index;
    logic        [5:0]  y_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;

    modport source (
        output valid, kind, x_index, y_index, sample_value, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, kind, x_index, y_index, sample_value, point_x, point_y,
        output ready
    );
endinterface

@@ sv/gbi_result_if.sv @@
`timescale 1ns / 1ps

// Output channel: one result per query
interface gbi_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interpolated_value;
    logic               inside_res;

    modport source (
        output valid, interpolated_value, inside_res,
        input  ready
    );
    modport sink (
        input  valid, interpolated_value, inside_res,
        output ready
    );
endinterface

@@ sv/gbi_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module gbi_ram #(
    parameter int AW = 10,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while the read enable is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ sv/gbi_locate.sv @@
`timescale 1ns / 1ps

// One axis: box test, offset times scale, cell index and fraction.
// Three register stages, all advancing on en.
module gbi_locate import gbi_pkg::*; #(
    parameter int GRID_SIZE = 64,
    parameter int CELL_W    = $clog2(GRID_SIZE)
) (
    input  logic               clk,
    input  logic               en,
    input  axis_cfg_t          cfg,
    input  logic signed [31:0] point,
    output logic               in_box,
    output logic [CELL_W-1:0]  cell_idx,
    output logic [16:0]        frac
);
    localparam int NW = ($clog2(GRID_SIZE + 1) > USED_W) ? $clog2(GRID_SIZE + 1) : USED_W;

    logic              inside_a_reg;
    logic [31:0]       diff_a_reg;
    logic              inside_b_reg;
    logic [63:0]       prod_b_reg;
    logic              inside_c_reg;
    logic [CELL_W-1:0] cell_c_reg;
    logic [16:0]       frac_c_reg;

    logic [NW-1:0]     used_ext;
    logic [NW-1:0]     npts;
    logic [NW-1:0]     last_cell;
    logic              past_last;

    // Stage A: box test and offset from lower bound
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_a_reg <= (point >= cfg.low) && (point < cfg.high);
            diff_a_reg   <= 32'(point - cfg.low);
        end
    end

    // Stage B: Q16.16 offset times Q16.16 scale gives Q32.32
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_b_reg <= inside_a_reg;
            prod_b_reg   <= diff_a_reg * cfg.scale;
        end
    end

    // Effective sample count and last cell
    always_comb
    begin
        used_ext = NW'(cfg.used);
        if (used_ext < NW'(2))
        begin
            npts = NW'(2);
        end
        else if (used_ext > NW'(GRID_SIZE))
        begin
            npts = NW'(GRID_SIZE);
        end
        else
        begin
            npts = used_ext;
        end
        last_cell = npts - NW'(2);
        past_last = prod_b_reg[63:32] > 32'(last_cell);
    end

    // Stage C: saturate past the last cell to its upper corner
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_c_reg <= inside_b_reg;
            if (past_last)
            begin
                cell_c_reg <= CELL_W'(last_cell);
                frac_c_reg <= ONE_Q16;
            end
            else
            begin
                cell_c_reg <= CELL_W'(prod_b_reg[63:32]);
                frac_c_reg <= {1'b0, prod_b_reg[31:16]};
            end
        end
    end

    assign in_box   = inside_c_reg;
    assign cell_idx = cell_c_reg;
    assign frac     = frac_c_reg;
endmodule

@@ sv/grid_bilinear_interpolator.sv @@
`timescale 1ns / 1ps

// Bilinear interpolator on a regular grid of Q16.16 samples. Takes one
// transaction per clock when the pipeline is not held, writes and queries
// mixed freely; each query gives one registered result, a write gives none.
// The grid store is split into four banks by the low bit of each index, so
// the four corners of any cell are read in the same cycle, one per bank;
// writes and reads use the banks at the same pipeline stage, so a query sees
// every write accepted before it. A stalled output holds the pipeline only
// when a further result is ready to take its place. Grid entries come out of
// reset undefined and must be written before a query reads them.
module grid_bilinear_interpolator import gbi_pkg::*; #(
    parameter int GRID_X_SIZE = 64,
    parameter int GRID_Y_SIZE = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    gbi_item_if.sink               item,
    gbi_result_if.source           result,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    localparam int XCW = $clog2(GRID_X_SIZE);
    localparam int YCW = $clog2(GRID_Y_SIZE);
    localparam int XAW = (XCW > 1) ? XCW - 1 : 1;
    localparam int YAW = (YCW > 1) ? YCW - 1 : 1;
    localparam int BAW = XAW + YAW;

    // Configuration registers
    logic signed [31:0] x_low_reg, x_high_reg, y_low_reg, y_high_reg;
    logic [31:0]        x_scale_reg, y_scale_reg;
    logic [6:0]         x_used_reg, y_used_reg;
    axis_cfg_t          x_cfg, y_cfg;

    // Pipeline control
    logic  adv;
    logic  res_load;
    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  q5_reg, q6_reg, q7_reg;
    logic  res_valid_reg;
    kind_t k1_reg, k2_reg, k3_reg, k4_reg;

    // Write payload carried to the memory stage
    logic [5:0]  wx1_reg, wx2_reg, wx3_reg, wx4_reg;
    logic [5:0]  wy1_reg, wy2_reg, wy3_reg, wy4_reg;
    logic [31:0] wd1_reg, wd2_reg, wd3_reg, wd4_reg;
    logic signed [31:0] px1_reg, py1_reg;

    // Locate outputs (stage 4)
    logic           ins_x, ins_y;
    logic [XCW-1:0] cell_x;
    logic [YCW-1:0] cell_y;
    logic [16:0]    frac_s, frac_t;
    logic [16:0]    s1, t1;

    // Memory stage
    logic           grid_wr;
    logic [XCW-1:0] wr_x;
    logic [YCW-1:0] wr_y;
    logic [31:0]    rd_data [4];

    // Blend stages
    logic           ins5_reg, ins6_reg, ins7_reg;
    logic           i0_5_reg, j0_5_reg;
    logic [32:0]    w5_reg [4];
    logic signed [31:0] corner [4];
    logic signed [65:0] prod_full [4];
    logic signed [63:0] prod6_reg [4];
    logic signed [63:0] sum_a7_reg, sum_b7_reg;
    logic signed [63:0] acc;
    logic signed [31:0] value_reg;
    logic               inside_reg;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg   <= LOW_RST;
            x_high_reg  <= HIGH_RST;
            y_low_reg   <= LOW_RST;
            y_high_reg  <= HIGH_RST;
            x_scale_reg <= SCALE_RST;
            y_scale_reg <= SCALE_RST;
            x_used_reg  <= USED_RST;
            y_used_reg  <= USED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_X_LOW:   x_low_reg   <= cfg_data;
                CFG_X_HIGH:  x_high_reg  <= cfg_data;
                CFG_Y_LOW:   y_low_reg   <= cfg_data;
                CFG_Y_HIGH:  y_high_reg  <= cfg_data;
                CFG_X_SCALE: x_scale_reg <= cfg_data;
                CFG_Y_SCALE: y_scale_reg <= cfg_data;
                CFG_X_USED:  x_used_reg  <= cfg_data[USED_W-1:0];
                CFG_Y_USED:  y_used_reg  <= cfg_data[USED_W-1:0];
                default: ;
            endcase
        end
    end

    assign x_cfg = '{low: x_low_reg, high: x_high_reg, scale: x_scale_reg, used: x_used_reg};
    assign y_cfg = '{low: y_low_reg, high: y_high_reg, scale: y_scale_reg, used: y_used_reg};

    // Flow control: output loads when empty or taken; the pipe moves
    // unless a waiting result would be overwritten
    assign res_load   = !res_valid_reg || result.ready;
    assign adv        = res_load || !q7_reg;
    assign item.ready = adv;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            q5_reg        <= 1'b0;
            q6_reg        <= 1'b0;
            q7_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            q5_reg <= v4_reg && (k4_reg == KIND_QUERY);
            q6_reg <= q5_reg;
            q7_reg <= q6_reg;
            if (res_load)
            begin
                res_valid_reg <= q7_reg;
            end
        end
    end

    // Stage 1 to 4 payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k1_reg  <= kind_t'(item.kind);
            wx1_reg <= item.x_index;
            wy1_reg <= item.y_index;
            wd1_reg <= item.sample_value;
            px1_reg <= item.point_x;
            py1_reg <= item.point_y;
            k2_reg  <= k1_reg;
            wx2_reg <= wx1_reg;
            wy2_reg <= wy1_reg;
            wd2_reg <= wd1_reg;
            k3_reg  <= k2_reg;
            wx3_reg <= wx2_reg;
            wy3_reg <= wy2_reg;
            wd3_reg <= wd2_reg;
            k4_reg  <= k3_reg;
            wx4_reg <= wx3_reg;
            wy4_reg <= wy3_reg;
            wd4_reg <= wd3_reg;
        end
    end

    // Cell and fraction per axis, stages 2 to 4
    gbi_locate #(
        .GRID_SIZE (GRID_X_SIZE),
        .CELL_W    (XCW)
    ) u_locate_x (
        .clk      (clk),
        .en       (adv),
        .cfg      (x_cfg),
        .point    (px1_reg),
        .in_box   (ins_x),
        .cell_idx (cell_x),
        .frac     (frac_s)
    );

    gbi_locate #(
        .GRID_SIZE (GRID_Y_SIZE),
        .CELL_W    (YCW)
    ) u_locate_y (
        .clk      (clk),
        .en       (adv),
        .cfg      (y_cfg),
        .point    (py1_reg),
        .in_box   (ins_y),
        .cell_idx (cell_y),
        .frac     (frac_t)
    );

    // Grid write at stage 4; indices past the grid are dropped
    assign wr_x    = XCW'(wx4_reg);
    assign wr_y    = YCW'(wy4_reg);
    assign grid_wr = adv && v4_reg && (k4_reg == KIND_WRITE)
                     && (32'(wx4_reg) < 32'(GRID_X_SIZE))
                     && (32'(wy4_reg) < 32'(GRID_Y_SIZE));

    // Four banks by index parity; each corner of a cell lands in its own bank
    for (genvar gb = 0; gb < 4; gb++)
    begin : g_bank
        localparam logic BX = 1'((gb >> 1) & 1);
        localparam logic BY = 1'(gb & 1);

        logic [XCW-1:0] rx, rx_half, wx_half;
        logic [YCW-1:0] ry, ry_half, wy_half;
        logic [BAW-1:0] raddr, waddr;
        logic           we;

        always_comb
        begin
            rx      = (cell_x[0] == BX) ? cell_x : cell_x + XCW'(1);
            ry      = (cell_y[0] == BY) ? cell_y : cell_y + YCW'(1);
            rx_half = rx >> 1;
            ry_half = ry >> 1;
            raddr   = {rx_half[XAW-1:0], ry_half[YAW-1:0]};
            wx_half = wr_x >> 1;
            wy_half = wr_y >> 1;
            waddr   = {wx_half[XAW-1:0], wy_half[YAW-1:0]};
            we      = grid_wr && (wr_x[0] == BX) && (wr_y[0] == BY);
        end

        gbi_ram #(
            .AW (BAW),
            .DW (32)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wd4_reg),
            .re    (adv),
            .raddr (raddr),
            .rdata (rd_data[gb])
        );
    end

    // Stage 5: corner weights, exact Q1.32, alongside the bank read
    assign s1 = ONE_Q16 - frac_s;
    assign t1 = ONE_Q16 - frac_t;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ins5_reg  <= ins_x && ins_y;
            i0_5_reg  <= cell_x[0];
            j0_5_reg  <= cell_y[0];
            w5_reg[0] <= 33'(s1 * t1);
            w5_reg[1] <= 33'(s1 * frac_t);
            w5_reg[2] <= 33'(frac_s * t1);
            w5_reg[3] <= 33'(frac_s * frac_t);
        end
    end

    // Route banks to corners and weight each sample
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            corner[c]    = rd_data[2'(c) ^ {i0_5_reg, j0_5_reg}];
            prod_full[c] = $signed({1'b0, w5_reg[c]}) * corner[c];
        end
    end

    // Stage 6: weighted samples
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ins6_reg <= ins5_reg;
            for (int c = 0; c < 4; c++)
            begin
                prod6_reg[c] <= prod_full[c][63:0];
            end
        end
    end

    // Stage 7: pairwise sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ins7_reg   <= ins6_reg;
            sum_a7_reg <= prod6_reg[0] + prod6_reg[1];
            sum_b7_reg <= prod6_reg[2] + prod6_reg[3];
        end
    end

    // Output register: round Q16.48 to nearest, ties up; zero outside
    assign acc = sum_a7_reg + sum_b7_reg + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (adv && res_load)
        begin
            inside_reg <= ins7_reg;
            value_reg  <= ins7_reg ? acc[63:32] : 32'sd0;
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.interpolated_value = value_reg;
    assign result.inside_res         = inside_reg;
endmodule

@@ sv/gbi_checker.sv @@
`timescale 1ns / 1ps

`include "grid_bilinear_interpolator_assert.svh"

// Port-level checks on the interpolator
module gbi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic signed [31:0] interpolated_value,
    input logic               inside_res
);
    // Nothing comes out of reset
    `GBI_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |-> !result_valid, "result valid during reset")

    // With no result pending the input side never stalls
    `GBI_ASSERT(a_ready_when_empty, clk, rst_n, !result_valid |-> item_ready, "input stalled with empty output")

    // A point outside the box reports zero
    `GBI_ASSERT(a_outside_zero, clk, rst_n, (result_valid && !inside_res) |-> (interpolated_value == 32'sd0), "nonzero value outside box")

    // A result waiting on the sink holds
    `GBI_ASSERT(a_result_hold, clk, rst_n, (result_valid && !result_ready) |=> (result_valid && $stable(interpolated_value) && $stable(inside_res)), "result changed while stalled")
endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .interpolated_value (result.interpolated_value),
    .inside_res         (result.inside_res)
);
